### rtl/crd_pkg.sv
`default_nettype none

package crd_pkg;

  localparam int FRAC_BITS = 14;

  localparam int DIR_W  = 16;
  localparam int IN_W   = 18;
  localparam int OUT_W  = 16;
  localparam int PROD_W = IN_W + DIR_W + 1;

  // vector ahead of normalization: x*R + y*U + d with 2*FRAC_BITS fraction bits
  localparam int VEC_W    = 36;
  localparam int MSB_W    = $clog2(VEC_W);
  localparam int MAG_W    = 30;
  localparam int NORM_MSB = MAG_W - 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int Q_W      = FRAC_BITS + 1;
  localparam int NUM_W    = MAG_W + FRAC_BITS + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 2'd2;

  localparam logic [DIR_W-1:0] DIR_X_RST = 16'd0;
  localparam logic [DIR_W-1:0] DIR_Y_RST = 16'd0;
  localparam logic [DIR_W-1:0] DIR_Z_RST = 16'd16384;

  typedef enum logic [1:0] {
    TAG_RAY   = 2'd0,
    TAG_RIGHT = 2'd1,
    TAG_UP    = 2'd2
  } tag_t;

  typedef logic [VEC_W-1:0] vec_comp_t;
  typedef vec_comp_t [2:0] vec_t;

  typedef struct packed {
    logic vld;
    tag_t tag;
    vec_t v;
  } vec_req_t;

  typedef struct packed {
    logic                  vld;
    tag_t                  tag;
    logic                  zero;
    logic [2:0][OUT_W-1:0] comp;
  } vec_rsp_t;

  typedef struct packed {
    logic       vld;
    tag_t       tag;
    logic       zero;
    logic [2:0] neg;
  } side_t;

endpackage

`default_nettype wire

### rtl/crd_sqrt_cell.sv
`default_nettype none

// one root bit per cell: brings down two radicand bits, trial subtract
module crd_sqrt_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [crd_pkg::SUM_W-1:0]  s_in,
  input  wire logic [crd_pkg::REM_W-1:0]  rem_in,
  input  wire logic [crd_pkg::ROOT_W-1:0] root_in,
  output logic      [crd_pkg::SUM_W-1:0]  s_r,
  output logic      [crd_pkg::REM_W-1:0]  rem_r,
  output logic      [crd_pkg::ROOT_W-1:0] root_r
);
  import crd_pkg::*;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  always_comb begin
    rem_sh = {rem_in[REM_W-3:0], s_in[SUM_W-1 -: 2]};
    trial  = REM_W'({root_in, 2'b01});
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_in[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_in[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_in << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/crd_div_cell.sv
`default_nettype none

// one quotient bit per cell, restoring division
module crd_div_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [crd_pkg::ROOT_W-1:0] den,
  input  wire logic [crd_pkg::ROOT_W-1:0] rem_in,
  input  wire logic [crd_pkg::Q_W-1:0]    num_in,
  input  wire logic [crd_pkg::Q_W-1:0]    q_in,
  output logic      [crd_pkg::ROOT_W-1:0] rem_r,
  output logic      [crd_pkg::Q_W-1:0]    num_r,
  output logic      [crd_pkg::Q_W-1:0]    q_r
);
  import crd_pkg::*;

  logic [ROOT_W:0]   rem_sh;
  logic [ROOT_W:0]   diff;
  logic [ROOT_W-1:0] rem_nxt;
  logic [Q_W-1:0]    q_nxt;

  always_comb begin
    rem_sh = {rem_in, num_in[Q_W-1]};
    diff   = rem_sh - (ROOT_W+1)'(den);
    if (rem_sh >= (ROOT_W+1)'(den)) begin
      rem_nxt = diff[ROOT_W-1:0];
      q_nxt   = {q_in[Q_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[ROOT_W-1:0];
      q_nxt   = {q_in[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_in << 1;
      q_r   <= q_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/crd_unit_vec.sv
`default_nettype none

// pipelined vector normalize: abs, msb find, align, square, sum,
// a row of root cells, then a row of divide cells per component
module crd_unit_vec (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              flush,
  input  wire crd_pkg::vec_req_t req,
  output crd_pkg::vec_rsp_t      rsp
);
  import crd_pkg::*;

  side_t                 sd1_r, sd2_r, sd3_r, sd4_r, sd5_r;
  logic [2:0][VEC_W-1:0] mag1_r, mag2_r;
  logic [MSB_W-1:0]      msb2_r;
  logic [2:0][MAG_W-1:0] mag3_r, mag4_r, mag5_r;
  logic [2:0][SQ_W-1:0]  sq4_r;
  logic [SUM_W-1:0]      sum5_r;

  side_t                 side1;
  side_t                 side2;
  logic [2:0][VEC_W-1:0] abs1;
  logic [VEC_W-1:0]      mx;
  logic [MSB_W-1:0]      msb;
  logic [2:0][MAG_W-1:0] al3;
  logic [VEC_W-1:0]      sh_tmp;

  always_comb begin
    side1.vld  = req.vld;
    side1.tag  = req.tag;
    side1.zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      side1.neg[i] = req.v[i][VEC_W-1];
      abs1[i]      = req.v[i][VEC_W-1] ? VEC_W'(-req.v[i]) : req.v[i];
    end
  end

  always_comb begin
    mx = mag1_r[0];
    if (mag1_r[1] > mx) mx = mag1_r[1];
    if (mag1_r[2] > mx) mx = mag1_r[2];
    msb = '0;
    for (int k = 0; k < VEC_W; k++) begin
      if (mx[k]) msb = MSB_W'(k);
    end
    side2      = sd1_r;
    side2.zero = (mx == '0);
  end

  // bring the largest component into [2^29, 2^30); right shifts truncate
  always_comb begin
    sh_tmp = '0;
    for (int i = 0; i < 3; i++) begin
      if (msb2_r > MSB_W'(NORM_MSB)) begin
        sh_tmp = mag2_r[i] >> (msb2_r - MSB_W'(NORM_MSB));
      end else begin
        sh_tmp = mag2_r[i] << (MSB_W'(NORM_MSB) - msb2_r);
      end
      al3[i] = sh_tmp[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      sd1_r.vld <= 1'b0;
      sd2_r.vld <= 1'b0;
      sd3_r.vld <= 1'b0;
      sd4_r.vld <= 1'b0;
      sd5_r.vld <= 1'b0;
    end else if (en) begin
      sd1_r     <= side1;
      sd2_r     <= side2;
      sd3_r     <= sd2_r;
      sd4_r     <= sd3_r;
      sd5_r     <= sd4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= abs1;
      mag2_r <= mag1_r;
      msb2_r <= msb;
      mag3_r <= al3;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= mag3_r[i] * mag3_r[i];
      end
      mag4_r <= mag3_r;
      sum5_r <= SUM_W'(sq4_r[0]) + SUM_W'(sq4_r[1]) + SUM_W'(sq4_r[2]);
      mag5_r <= mag4_r;
    end
  end

  // root row
  logic [SUM_W-1:0]      s_st   [ROOT_W+1];
  logic [REM_W-1:0]      rem_st [ROOT_W+1];
  logic [ROOT_W-1:0]     root_st[ROOT_W+1];
  side_t                 sds    [ROOT_W+1];
  logic [2:0][MAG_W-1:0] mags   [ROOT_W+1];

  assign s_st[0]    = sum5_r;
  assign rem_st[0]  = '0;
  assign root_st[0] = '0;
  assign sds[0]     = sd5_r;
  assign mags[0]    = mag5_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    crd_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .s_in   (s_st[k]),
      .rem_in (rem_st[k]),
      .root_in(root_st[k]),
      .s_r    (s_st[k+1]),
      .rem_r  (rem_st[k+1]),
      .root_r (root_st[k+1])
    );

    side_t                 sd_r;
    logic [2:0][MAG_W-1:0] mag_r;

    always_ff @(posedge clk) begin
      if (!rst_n || flush) begin
        sd_r.vld <= 1'b0;
      end else if (en) begin
        sd_r <= sds[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) mag_r <= mags[k];
    end

    assign sds[k+1]  = sd_r;
    assign mags[k+1] = mag_r;
  end

  // divide setup: rounded (mag << FRAC_BITS) / len
  logic [ROOT_W-1:0]          len;
  logic [2:0][NUM_W-1:0]      num;
  side_t                      sdp_r;
  logic [ROOT_W-1:0]          denp_r;
  logic [2:0][ROOT_W-1:0]     remp_r;
  logic [2:0][Q_W-1:0]        nump_r;

  assign len = root_st[ROOT_W];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUM_W'(mags[ROOT_W][i]) << FRAC_BITS) + NUM_W'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      sdp_r.vld <= 1'b0;
    end else if (en) begin
      sdp_r <= sds[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      denp_r <= len;
      for (int i = 0; i < 3; i++) begin
        remp_r[i] <= ROOT_W'(num[i] >> Q_W);
        nump_r[i] <= num[i][Q_W-1:0];
      end
    end
  end

  // divide row
  logic [2:0][ROOT_W-1:0] drem[Q_W+1];
  logic [2:0][Q_W-1:0]    dnum[Q_W+1];
  logic [2:0][Q_W-1:0]    dq  [Q_W+1];
  logic [ROOT_W-1:0]      dden[Q_W+1];
  side_t                  sdd [Q_W+1];

  assign drem[0] = remp_r;
  assign dnum[0] = nump_r;
  assign dq[0]   = '0;
  assign dden[0] = denp_r;
  assign sdd[0]  = sdp_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_comp
      crd_div_cell u_cell (
        .clk   (clk),
        .en    (en),
        .den   (dden[k]),
        .rem_in(drem[k][i]),
        .num_in(dnum[k][i]),
        .q_in  (dq[k][i]),
        .rem_r (drem[k+1][i]),
        .num_r (dnum[k+1][i]),
        .q_r   (dq[k+1][i])
      );
    end

    side_t             sd_r;
    logic [ROOT_W-1:0] den_r;

    always_ff @(posedge clk) begin
      if (!rst_n || flush) begin
        sd_r.vld <= 1'b0;
      end else if (en) begin
        sd_r <= sdd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) den_r <= dden[k];
    end

    assign sdd[k+1]  = sd_r;
    assign dden[k+1] = den_r;
  end

  always_comb begin
    rsp.vld  = sdd[Q_W].vld;
    rsp.tag  = sdd[Q_W].tag;
    rsp.zero = sdd[Q_W].zero;
    for (int i = 0; i < 3; i++) begin
      rsp.comp[i] = sdd[Q_W].neg[i] ? OUT_W'(-OUT_W'(dq[Q_W][i])) : OUT_W'(dq[Q_W][i]);
    end
  end

endmodule

`default_nettype wire

### rtl/camera_ray_direction.sv
`default_nettype none

// Pinhole look-at primary-ray generator. Each request carries screen-plane
// offsets (Q3.14) and yields normalize(x*R + y*U + d) in Q1.14, where R and U
// are the right and up vectors derived from the view direction d (Q1.14).
// A fully pipelined normalize unit (a row of 31 square-root cells followed by
// three rows of 15 divide cells, one per component) takes one request per
// clock while the output is not stalled. After reset and after any cfg_we
// write the block passes R and then U through that unit to rebuild them, with
// in_ready low; U is skipped if R has zero length. A zero-length basis or ray
// sets out_degenerate and zeroes the ray.
module camera_ray_direction (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [crd_pkg::IN_W-1:0]   in_x_offset,
  input  wire logic signed [crd_pkg::IN_W-1:0]   in_y_offset,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [crd_pkg::OUT_W-1:0]       out_ray_x,
  output logic signed [crd_pkg::OUT_W-1:0]       out_ray_y,
  output logic signed [crd_pkg::OUT_W-1:0]       out_ray_z,
  output logic                                   out_degenerate,
  input  wire logic                              cfg_we,
  input  wire logic [crd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [crd_pkg::DIR_W-1:0]         cfg_wdata
);
  import crd_pkg::*;

  typedef enum logic [4:0] {
    S_BASIS_R = 5'b00001,
    S_WAIT_R  = 5'b00010,
    S_BASIS_U = 5'b00100,
    S_WAIT_U  = 5'b01000,
    S_RUN     = 5'b10000
  } state_t;

  state_t state_r;
  logic   bad_r;

  logic signed [DIR_W-1:0] dir_r[3];
  logic signed [OUT_W-1:0] rt_r[3];
  logic signed [OUT_W-1:0] up_r[3];

  vec_req_t req_r;
  vec_rsp_t rsp;
  logic     adv;
  logic     inject;
  tag_t     inj_tag;
  logic     cap_r, cap_u;
  logic     rsp_ray;

  logic                    a_vld_r;
  tag_t                    a_tag_r;
  logic signed [PROD_W-1:0] pa_r[3];
  logic signed [PROD_W-1:0] pb_r[3];
  logic signed [VEC_W-1:0]  pc_r[3];

  logic signed [IN_W-1:0]  m1[3], m2[3];
  logic signed [DIR_W:0]   n1[3], n2[3];
  logic signed [VEC_W-1:0] c[3];

  logic                    out_valid_r;
  logic                    out_deg_r;
  logic [2:0][OUT_W-1:0]   out_comp_r;

  // pipeline moves unless a ray sits at the end with the output register full and out_ready low
  assign rsp_ray  = rsp.vld && (rsp.tag == TAG_RAY);
  assign adv      = !out_valid_r || out_ready || !rsp_ray;
  assign in_ready = (state_r == S_RUN) && adv;
  assign cap_r    = adv && rsp.vld && (rsp.tag == TAG_RIGHT);
  assign cap_u    = adv && rsp.vld && (rsp.tag == TAG_UP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r[0] <= DIR_X_RST;
      dir_r[1] <= DIR_Y_RST;
      dir_r[2] <= DIR_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIR_X: dir_r[0] <= cfg_wdata;
        CFG_DIR_Y: dir_r[1] <= cfg_wdata;
        CFG_DIR_Z: dir_r[2] <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BASIS_R;
      bad_r   <= 1'b0;
    end else if (cfg_we) begin
      state_r <= S_BASIS_R;
    end else begin
      case (state_r)
        S_BASIS_R: if (adv) state_r <= S_WAIT_R;
        S_WAIT_R: begin
          if (cap_r) begin
            bad_r   <= rsp.zero;
            state_r <= rsp.zero ? S_RUN : S_BASIS_U;
          end
        end
        S_BASIS_U: if (adv) state_r <= S_WAIT_U;
        S_WAIT_U: begin
          if (cap_u) begin
            bad_r   <= rsp.zero;
            state_r <= S_RUN;
          end
        end
        S_RUN:   ;
        default: state_r <= S_BASIS_R;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cap_r) rt_r[i] <= rsp.comp[i];
      if (cap_u) up_r[i] <= rsp.comp[i];
    end
  end

  // operand select: rays, up = R x d, right = (-dz, 0, dx)
  always_comb begin
    inject  = 1'b0;
    inj_tag = TAG_RAY;
    for (int i = 0; i < 3; i++) begin
      m1[i] = '0;
      n1[i] = '0;
      m2[i] = '0;
      n2[i] = '0;
      c[i]  = '0;
    end
    case (state_r)
      S_RUN: begin
        inject = in_valid;
        for (int i = 0; i < 3; i++) begin
          m1[i] = in_x_offset;
          n1[i] = (DIR_W+1)'(rt_r[i]);
          m2[i] = in_y_offset;
          n2[i] = (DIR_W+1)'(up_r[i]);
          c[i]  = VEC_W'(dir_r[i]) <<< FRAC_BITS;
        end
      end
      S_BASIS_U: begin
        inject  = 1'b1;
        inj_tag = TAG_UP;
        m1[0]   = -IN_W'(rt_r[2]);
        n1[0]   = (DIR_W+1)'(dir_r[1]);
        m1[1]   = IN_W'(rt_r[2]);
        n1[1]   = (DIR_W+1)'(dir_r[0]);
        m2[1]   = -IN_W'(rt_r[0]);
        n2[1]   = (DIR_W+1)'(dir_r[2]);
        m1[2]   = IN_W'(rt_r[0]);
        n1[2]   = (DIR_W+1)'(dir_r[1]);
      end
      S_BASIS_R: begin
        inject  = 1'b1;
        inj_tag = TAG_RIGHT;
        c[0]    = -VEC_W'(dir_r[2]);
        c[2]    = VEC_W'(dir_r[0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      a_vld_r   <= 1'b0;
      req_r.vld <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= inject;
      a_tag_r   <= inj_tag;
      req_r.vld <= a_vld_r;
      req_r.tag <= a_tag_r;
      for (int i = 0; i < 3; i++) begin
        req_r.v[i] <= VEC_W'(pa_r[i]) + VEC_W'(pb_r[i]) + pc_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i]     <= m1[i] * n1[i];
        pb_r[i]     <= m2[i] * n2[i];
        pc_r[i]     <= c[i];
      end
    end
  end

  crd_unit_vec u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .flush(cfg_we),
    .req  (req_r),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= rsp_ray;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_deg_r <= rsp.zero || bad_r;
      for (int i = 0; i < 3; i++) begin
        out_comp_r[i] <= (rsp.zero || bad_r) ? '0 : rsp.comp[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ray_x      = out_comp_r[0];
  assign out_ray_y      = out_comp_r[1];
  assign out_ray_z      = out_comp_r[2];
  assign out_degenerate = out_deg_r;

`ifndef SYNTHESIS
  a_basis_only_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.vld && rsp.tag != TAG_RAY) |-> (state_r == S_WAIT_R || state_r == S_WAIT_U))
    else $error("basis result outside a wait state");

  a_no_ray_while_rebuilding: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> !rsp_ray)
    else $error("ray in flight while basis is rebuilt");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |->
      ($signed(out_ray_x) <= 16384 && $signed(out_ray_x) >= -16384 &&
       $signed(out_ray_y) <= 16384 && $signed(out_ray_y) >= -16384 &&
       $signed(out_ray_z) <= 16384 && $signed(out_ray_z) >= -16384))
    else $error("ray component beyond unit range");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_ray_x == '0 && out_ray_y == '0 && out_ray_z == '0))
    else $error("degenerate ray not zeroed");
`endif

endmodule

`default_nettype wire
